FILE: src/histeq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Histogram equalizer package
// Shared widths, command codes and a helper function for the histogram
// equalizer and its divider.
// ----------------------------------------------------------------------------
package histeq_pkg;

    // Histogram geometry and field widths.
    localparam int NUM_BINS   = 256;
    localparam int BIN_W      = $clog2(NUM_BINS);
    localparam int COUNT_W    = 24;
    localparam int COLOUR_W   = 24;
    localparam int VALUE_W    = 16;
    localparam int CMD_W      = 2;
    localparam int PROD_W     = COUNT_W + COLOUR_W;
    localparam int DIV_STEP_W = $clog2(COLOUR_W);

    // Command codes carried on the input channel.
    localparam logic [CMD_W-1:0] CMD_COUNT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_MAP   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    localparam logic [COUNT_W-1:0]  COUNT_MAX    = '1;
    localparam logic [COLOUR_W-1:0] COLOUR_RESET = '1;
    localparam logic [BIN_W-1:0]    LAST_BIN     = BIN_W'(NUM_BINS - 1);

    // Values beyond the last bin fall into the last bin.
    function automatic logic [BIN_W-1:0] clamp_bin(input logic [VALUE_W-1:0] value);
        logic [BIN_W-1:0] bin;
        if (value >= VALUE_W'(NUM_BINS)) begin
            bin = LAST_BIN;
        end else begin
            bin = value[BIN_W-1:0];
        end
        return bin;
    endfunction

endpackage

FILE: src/histogram_equalizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Histogram equalizer
// Counts pixel values into a 256-bin histogram and maps values to
// equalized colours through a per-bin colour table held in RAM.
// ----------------------------------------------------------------------------
// A count reads the bin and writes it back in S_COUNT; a map reads the
//   table and registers the colour in S_MAP; clear and unused commands end in idle.
// The first map after a count, clear or scale write rebuilds the table:
//   bin by bin it loads the count, multiplies, runs the 24-step divider and
//   writes the quotient, then reads the requested bin for the output register.
// Throughput: one item at a time; the input is ready only in the idle state.
// Reset clears the histogram valid bits, the total and the output valid flag,
//   sets the full-scale colour to its top value and marks the table stale.
// ----------------------------------------------------------------------------
module histogram_equalizer import histeq_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [COLOUR_W-1:0] cfg_wdata,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [CMD_W-1:0]    s_cmd,
    input  logic [VALUE_W-1:0]  s_value,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [COLOUR_W-1:0] m_colour
);

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_COUNT    = 7'b0000010,
        S_RB_LOAD  = 7'b0000100,
        S_RB_START = 7'b0001000,
        S_RB_DIV   = 7'b0010000,
        S_MAP_RD   = 7'b0100000,
        S_MAP      = 7'b1000000
    } state_t;

    state_t               state_reg, state_next;
    logic [BIN_W-1:0]     bin_reg, bin_next;
    logic [BIN_W-1:0]     idx_reg, idx_next;
    logic [COUNT_W-1:0]   below_reg, below_next;
    logic [COUNT_W-1:0]   total_reg, total_next;
    logic                 stale_reg, stale_next;
    logic [COLOUR_W-1:0]  full_scale_reg, full_scale_next;
    logic [NUM_BINS-1:0]  valid_reg, valid_next;
    logic [PROD_W-1:0]    prod_reg, prod_next;
    logic                 m_valid_reg, m_valid_next;
    logic [COLOUR_W-1:0]  m_colour_reg, m_colour_next;

    logic [BIN_W-1:0]     s_bin;
    logic [BIN_W-1:0]     idx_inc;
    logic [BIN_W-1:0]     cnt_sel;
    logic [COUNT_W-1:0]   cnt_cur;
    logic [COUNT_W:0]     below_sum;
    logic [PROD_W-1:0]    mul_out;

    logic                 cnt_re, cnt_we;
    logic [BIN_W-1:0]     cnt_raddr;
    logic [COUNT_W-1:0]   cnt_rdata, cnt_wdata;
    logic                 tab_re, tab_we;
    logic [BIN_W-1:0]     tab_raddr;
    logic [COLOUR_W-1:0]  tab_rdata;

    logic                 div_start, div_done;
    logic [COLOUR_W-1:0]  div_quotient;

    // Histogram counts; an entry without its valid bit reads as zero.
    histeq_ram #(.WIDTH(COUNT_W), .DEPTH(NUM_BINS)) u_count_ram (
        .aclk  (aclk),
        .we    (cnt_we),
        .waddr (bin_reg),
        .wdata (cnt_wdata),
        .re    (cnt_re),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    // Colour table, written during a rebuild at the bin being walked.
    histeq_ram #(.WIDTH(COLOUR_W), .DEPTH(NUM_BINS)) u_table_ram (
        .aclk  (aclk),
        .we    (tab_we),
        .waddr (idx_reg),
        .wdata (div_quotient),
        .re    (tab_re),
        .raddr (tab_raddr),
        .rdata (tab_rdata)
    );

    // Divider for below * full scale / total, used by the table rebuild.
    histeq_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (total_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // Bin selection and count arithmetic.
    assign s_bin     = clamp_bin(s_value);
    assign idx_inc   = idx_reg + BIN_W'(1);
    assign cnt_sel   = (state_reg == S_COUNT) ? bin_reg : idx_reg;
    assign cnt_cur   = valid_reg[cnt_sel] ? cnt_rdata : '0;
    assign cnt_wdata = (cnt_cur == COUNT_MAX) ? cnt_cur : cnt_cur + COUNT_W'(1);
    assign below_sum = {1'b0, below_reg} + {1'b0, cnt_cur};
    assign mul_out   = PROD_W'(below_reg) * PROD_W'(full_scale_reg);

    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_colour = m_colour_reg;

    // Sequencer: count, map and the table rebuild walk.
    always_comb begin
        state_next      = state_reg;
        bin_next        = bin_reg;
        idx_next        = idx_reg;
        below_next      = below_reg;
        total_next      = total_reg;
        stale_next      = stale_reg;
        full_scale_next = full_scale_reg;
        valid_next      = valid_reg;
        prod_next       = prod_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_colour_next   = m_colour_reg;
        cnt_re          = 1'b0;
        cnt_raddr       = s_bin;
        cnt_we          = 1'b0;
        tab_re          = 1'b0;
        tab_raddr       = s_bin;
        tab_we          = 1'b0;
        div_start       = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    bin_next = s_bin;
                    unique case (s_cmd)
                        CMD_COUNT: begin
                            cnt_re     = 1'b1;
                            state_next = S_COUNT;
                        end
                        CMD_MAP: begin
                            if (stale_reg) begin
                                idx_next   = '0;
                                below_next = '0;
                                cnt_re     = 1'b1;
                                cnt_raddr  = '0;
                                state_next = S_RB_LOAD;
                            end else begin
                                tab_re     = 1'b1;
                                state_next = S_MAP;
                            end
                        end
                        CMD_CLEAR: begin
                            valid_next = '0;
                            total_next = '0;
                            stale_next = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_COUNT: begin
                // Read-modify-write of the bin; the count saturates.
                cnt_we              = 1'b1;
                valid_next[bin_reg] = 1'b1;
                if (total_reg != COUNT_MAX) begin
                    total_next = total_reg + COUNT_W'(1);
                end
                stale_next = 1'b1;
                state_next = S_IDLE;
            end
            S_RB_LOAD: begin
                // The running sum is held at the total, which caps the colour.
                prod_next = mul_out;
                if (below_sum > {1'b0, total_reg}) begin
                    below_next = total_reg;
                end else begin
                    below_next = below_sum[COUNT_W-1:0];
                end
                state_next = S_RB_START;
            end
            S_RB_START: begin
                div_start  = 1'b1;
                state_next = S_RB_DIV;
            end
            S_RB_DIV: begin
                if (div_done) begin
                    tab_we = 1'b1;
                    if (idx_reg == LAST_BIN) begin
                        stale_next = 1'b0;
                        state_next = S_MAP_RD;
                    end else begin
                        idx_next   = idx_inc;
                        cnt_re     = 1'b1;
                        cnt_raddr  = idx_inc;
                        state_next = S_RB_LOAD;
                    end
                end
            end
            S_MAP_RD: begin
                tab_re     = 1'b1;
                tab_raddr  = bin_reg;
                state_next = S_MAP;
            end
            S_MAP: begin
                // Wait for room in the output register.
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_colour_next = tab_rdata;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // A new scale makes the table stale.
        if (cfg_we) begin
            full_scale_next = cfg_wdata;
            stale_next      = 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            total_reg      <= '0;
            stale_reg      <= 1'b1;
            full_scale_reg <= COLOUR_RESET;
            valid_reg      <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            total_reg      <= total_next;
            stale_reg      <= stale_next;
            full_scale_reg <= full_scale_next;
            valid_reg      <= valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        bin_reg      <= bin_next;
        idx_reg      <= idx_next;
        below_reg    <= below_next;
        prod_reg     <= prod_next;
        m_colour_reg <= m_colour_next;
    end

    // The table is fresh when a rebuilt map reads it.
    a_map_fresh: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_MAP_RD |-> !stale_reg)
        else $error("map read from a stale colour table");

    // The running sum never exceeds the total during a rebuild.
    a_below_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_RB_DIV |-> below_reg <= total_reg)
        else $error("running sum above sample total");

    // Every table entry lies within the colour range.
    a_quot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> div_quotient <= full_scale_reg)
        else $error("colour above the full-scale value");

    // A count always leaves the table stale.
    a_count_stale: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_COUNT |=> stale_reg)
        else $error("table not stale after a count");

endmodule

FILE: src/histeq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with a registered read. The read data
// holds its value until the next read.
// ----------------------------------------------------------------------------
module histeq_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: src/histeq_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Histogram equalizer divider
// Restoring divider that produces one quotient bit per cycle. The quotient
// is known to fit COLOUR_W bits, so only that many steps are taken.
// ----------------------------------------------------------------------------
module histeq_div import histeq_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [PROD_W-1:0]   dividend,
    input  logic [COUNT_W-1:0]  divisor,
    output logic                done,
    output logic [COLOUR_W-1:0] quotient
);

    localparam logic [DIV_STEP_W-1:0] LAST_STEP = DIV_STEP_W'(COLOUR_W - 1);

    logic                  busy_reg, busy_next;
    logic [DIV_STEP_W-1:0] step_reg, step_next;
    logic [COUNT_W-1:0]    rem_reg, rem_next;
    logic [COLOUR_W-1:0]   dq_reg, dq_next;
    logic [COUNT_W-1:0]    dvs_reg, dvs_next;
    logic                  zero_reg, zero_next;

    logic [COUNT_W:0]      trial;
    logic [COUNT_W-1:0]    diff;
    logic                  fits;
    logic [COLOUR_W-1:0]   dq_shift;

    // One trial subtraction per cycle; when it fits, the difference is
    // below the divisor and needs only COUNT_W bits.
    always_comb begin
        trial    = {rem_reg, dq_reg[COLOUR_W-1]};
        diff     = trial[COUNT_W-1:0] - dvs_reg;
        fits     = (trial >= {1'b0, dvs_reg});
        dq_shift = {dq_reg[COLOUR_W-2:0], fits};
    end

    // The last step's quotient goes straight out; a zero divisor gives zero.
    assign done     = busy_reg && (step_reg == LAST_STEP);
    assign quotient = zero_reg ? '0 : dq_shift;

    // Next-state logic of the divider.
    always_comb begin
        busy_next = busy_reg;
        step_next = step_reg;
        rem_next  = rem_reg;
        dq_next   = dq_reg;
        dvs_next  = dvs_reg;
        zero_next = zero_reg;
        if (start) begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = dividend[PROD_W-1:COLOUR_W];
            dq_next   = dividend[COLOUR_W-1:0];
            dvs_next  = divisor;
            zero_next = (divisor == '0);
        end else if (busy_reg) begin
            rem_next  = fits ? diff : trial[COUNT_W-1:0];
            dq_next   = dq_shift;
            step_next = step_reg + DIV_STEP_W'(1);
            if (done) begin
                busy_next = 1'b0;
            end
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        rem_reg  <= rem_next;
        dq_reg   <= dq_next;
        dvs_reg  <= dvs_next;
        zero_reg <= zero_next;
    end

    // The partial remainder always stays below a nonzero divisor.
    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && !zero_reg |-> rem_reg < dvs_reg)
        else $error("divider remainder not below divisor");

endmodule
